>>> hw/rtl/qdc_ewd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qdc_ewd_pkg
// Shared constants, word-type codes and controller/datapath interface types
// for the QDC event word deframer.
// ----------------------------------------------------------------------------
package qdc_ewd_pkg;

  localparam int NumChannelsDefault = 32;
  localparam int StoreDepth         = 32;
  localparam int StoreIdxW          = $clog2(StoreDepth);

  localparam int WordW    = 32;
  localparam int AdcW     = 12;
  localparam int AdcOutW  = 16;
  localparam int TrigW    = 24;
  localparam int ChanW    = 5;
  localparam int CountW   = 6;

  // word type, bits 26..25
  typedef enum logic [1:0] {
    WT_DATA   = 2'b00,
    WT_HEADER = 2'b01,
    WT_EOB    = 2'b10,
    WT_FILLER = 2'b11
  } word_type_t;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_DATA   = 3'b010,
    PH_EOB    = 3'b100
  } parse_phase_t;

  typedef struct packed {
    logic take;
    logic emit_start;
    logic advance;
  } ewd_cmd_t;

  typedef struct packed {
    logic close;
    logic last_chan;
  } ewd_status_t;

endpackage : qdc_ewd_pkg
`default_nettype wire

>>> hw/rtl/qdc_ewd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qdc_ewd_ctrl
// Sequencer: takes words one per cycle while idle, and after an event-closing
// word steps the datapath through the per-channel result burst.
// ----------------------------------------------------------------------------
module qdc_ewd_ctrl
  import qdc_ewd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  input  wire ewd_status_t status,
  output ewd_cmd_t         cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    cmd.take       = 1'b0;
    cmd.emit_start = 1'b0;
    cmd.advance    = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (status.close) begin
            cmd.emit_start = 1'b1;
            state_next     = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.advance = 1'b1;
          if (status.last_chan) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule : qdc_ewd_ctrl
`default_nettype wire

>>> hw/rtl/qdc_ewd_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qdc_ewd_datapath
// Word decode, parse phase, channel counters, ADC store with per-channel
// valid bits, trigger capture and the result channel counter.
// ----------------------------------------------------------------------------
module qdc_ewd_datapath
  import qdc_ewd_pkg::*;
#(
  parameter int NUM_CHANNELS = NumChannelsDefault
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic               cfg_wr_data,
  input  wire logic [WordW-1:0]   data_word,
  input  wire ewd_cmd_t           cmd,
  output ewd_status_t             status,
  output logic [ChanW-1:0]        channel,
  output logic [AdcOutW-1:0]      adc_value,
  output logic [TrigW-1:0]        trigger_number,
  output logic                    trigger_valid,
  output logic                    data_error,
  output logic                    last
);

  logic                  sixteen_mode;
  parse_phase_t          phase;
  logic [CountW-1:0]     expected;
  logic [CountW-1:0]     seen;
  logic                  err;
  logic [StoreDepth-1:0] vld;
  logic [AdcW-1:0]       vals [StoreDepth];
  logic [TrigW-1:0]      trig;
  logic                  trig_ok;
  logic [ChanW-1:0]      k;

  word_type_t        wtype;
  logic [CountW-1:0] chan_idx;
  logic              in_range;
  logic              is_filler;

  assign wtype     = word_type_t'(data_word[26:25]);
  assign is_filler = (wtype == WT_FILLER);
  assign chan_idx  = sixteen_mode ? data_word[22:17] : data_word[21:16];
  assign in_range  = (chan_idx < CountW'(NUM_CHANNELS));

  assign status.close     = !is_filler && (phase == PH_EOB);
  assign status.last_chan = (k == ChanW'(NUM_CHANNELS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      sixteen_mode <= 1'b0;
      phase        <= PH_HEADER;
      expected     <= '0;
      seen         <= '0;
      err          <= 1'b0;
      vld          <= '0;
      k            <= '0;
    end else begin
      if (cfg_wr_en) begin
        sixteen_mode <= cfg_wr_data;
      end
      if (cmd.take && !is_filler) begin
        case (phase)
          PH_DATA: begin
            if (wtype != WT_DATA) begin
              err <= 1'b1;
            end else begin
              if (in_range) begin
                vld[chan_idx[StoreIdxW-1:0]] <= 1'b1;
              end
              if (seen == CountW'(expected - CountW'(1))) begin
                phase <= PH_EOB;
              end
              seen <= CountW'(seen + CountW'(1));
            end
          end
          PH_EOB: begin
            if (wtype != WT_EOB) begin
              err <= 1'b1;
            end else begin
              phase <= PH_HEADER;
            end
          end
          default: begin
            if (wtype != WT_HEADER) begin
              err <= 1'b1;
            end else begin
              expected <= data_word[13:8];
              seen     <= '0;
              vld      <= '0;
              phase    <= (data_word[13:8] != '0) ? PH_DATA : PH_EOB;
            end
          end
        endcase
      end
      if (cmd.emit_start) begin
        k <= '0;
      end else if (cmd.advance) begin
        k <= ChanW'(k + ChanW'(1));
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take && (phase == PH_DATA) && (wtype == WT_DATA) && in_range) begin
      vals[chan_idx[StoreIdxW-1:0]] <= data_word[AdcW-1:0];
    end
    if (cmd.emit_start) begin
      trig_ok <= (wtype == WT_EOB);
      trig    <= (wtype == WT_EOB) ? data_word[TrigW-1:0] : '0;
    end
  end

  assign channel        = k;
  assign adc_value      = vld[k[StoreIdxW-1:0]]
                          ? {{(AdcOutW-AdcW){1'b0}}, vals[k[StoreIdxW-1:0]]}
                          : {AdcOutW{1'b1}};
  assign trigger_number = trig;
  assign trigger_valid  = trig_ok;
  assign data_error     = err;
  assign last           = status.last_chan;

endmodule : qdc_ewd_datapath
`default_nettype wire

>>> hw/rtl/qdc_event_word_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qdc_event_word_deframer
// Parses charge-digitizer readout words (header, channel data, end of block)
// and emits one result per channel when an event closes.
// ----------------------------------------------------------------------------
// Header, data and filler words are taken one per cycle. A non-filler word that
// arrives in the end-of-block phase closes the event: once it is taken, the
// channel counter walks the store and puts out NUM_CHANNELS results, one per
// accepted output transaction, during which no input is taken. Missing
// channels read as 65535. data_error is sticky from reset.
module qdc_event_word_deframer
  import qdc_ewd_pkg::*;
#(
  parameter int NUM_CHANNELS = NumChannelsDefault
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic                 cfg_wr_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [WordW-1:0]     data_word,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [ChanW-1:0]          channel,
  output logic [AdcOutW-1:0]        adc_value,
  output logic [TrigW-1:0]          trigger_number,
  output logic                      trigger_valid,
  output logic                      data_error,
  output logic                      last
);

  ewd_cmd_t    cmd;
  ewd_status_t status;

  qdc_ewd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  qdc_ewd_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .data_word      (data_word),
    .cmd            (cmd),
    .status         (status),
    .channel        (channel),
    .adc_value      (adc_value),
    .trigger_number (trigger_number),
    .trigger_valid  (trigger_valid),
    .data_error     (data_error),
    .last           (last)
  );

  a_no_input_during_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken during result burst");

  a_close_starts_burst: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && status.close) |=> (out_valid && channel == '0))
    else $error("closing word did not start burst at channel 0");

  a_last_ends_burst: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> (in_ready && !out_valid))
    else $error("burst did not end after last channel");

endmodule : qdc_event_word_deframer
`default_nettype wire

>>> tb/qdc_ewd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdc_ewd_checker
// Watches both channels and the mode register of the event word deframer.
// Each accepted readout word is decoded in step with the block's own parse
// state, and every closed event queues its per-channel results. Accepted
// output transactions are checked field by field, in order.
// ----------------------------------------------------------------------------
module qdc_ewd_checker
  import qdc_ewd_pkg::*;
#(
  parameter int NUM_CHANNELS = NumChannelsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [WordW-1:0]     data_word,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [ChanW-1:0]     channel,
  input  logic [AdcOutW-1:0]   adc_value,
  input  logic [TrigW-1:0]     trigger_number,
  input  logic                 trigger_valid,
  input  logic                 data_error,
  input  logic                 last,
  output int                   mismatches,
  output int                   outstanding,
  output int                   results_checked
);

  typedef struct packed {
    logic [ChanW-1:0]   channel;
    logic [AdcOutW-1:0] adc;
    logic [TrigW-1:0]   trig;
    logic               trig_ok;
    logic               err;
    logic               last;
  } chan_result_t;

  logic                sixteen_mode;
  parse_phase_t        phase;
  logic [CountW-1:0]   chan_count;
  logic [CountW-1:0]   chans_taken;
  logic [AdcOutW-1:0]  adc_shadow [StoreDepth];
  logic                sticky_err;
  chan_result_t        event_results [$];
  chan_result_t        want;
  int                  fail_count = 0;
  int                  pending_count = 0;
  int                  checked_count = 0;

  assign mismatches      = fail_count;
  assign outstanding     = pending_count;
  assign results_checked = checked_count;

  function automatic void decode_word(input logic [WordW-1:0] w);
    word_type_t        wt;
    logic [CountW-1:0] idx;
    logic              closed_ok;
    logic [TrigW-1:0]  trig;
    chan_result_t      r;
    wt = word_type_t'(w[26:25]);
    if (wt == WT_FILLER) return;
    case (phase)
      PH_DATA: begin
        if (wt != WT_DATA) begin
          sticky_err = 1'b1;
        end else begin
          idx = sixteen_mode ? w[22:17] : w[21:16];
          if (idx < NUM_CHANNELS) adc_shadow[idx[StoreIdxW-1:0]] = AdcOutW'(w[AdcW-1:0]);
          if (chans_taken == CountW'(chan_count - 1'b1)) phase = PH_EOB;
          chans_taken = chans_taken + 1'b1;
        end
      end
      PH_EOB: begin
        if (wt != WT_EOB) begin
          sticky_err = 1'b1;
          closed_ok  = 1'b0;
          trig       = '0;
        end else begin
          phase     = PH_HEADER;
          closed_ok = 1'b1;
          trig      = w[TrigW-1:0];
        end
        for (int k = 0; k < NUM_CHANNELS; k++) begin
          r.channel = k[ChanW-1:0];
          r.adc     = adc_shadow[k[StoreIdxW-1:0]];
          r.trig    = trig;
          r.trig_ok = closed_ok;
          r.err     = sticky_err;
          r.last    = (k == NUM_CHANNELS - 1);
          event_results.push_back(r);
        end
      end
      default: begin
        // header phase; an unknown phase code is handled the same way
        if (wt != WT_HEADER) begin
          sticky_err = 1'b1;
        end else begin
          chan_count  = w[13:8];
          chans_taken = '0;
          foreach (adc_shadow[i]) adc_shadow[i] = '1;
          phase = (chan_count != 0) ? PH_DATA : PH_EOB;
        end
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      sixteen_mode = 1'b0;
      phase        = PH_HEADER;
      chan_count   = '0;
      chans_taken  = '0;
      sticky_err   = 1'b0;
      foreach (adc_shadow[i]) adc_shadow[i] = '1;
      event_results.delete();
    end else begin
      if (in_valid && in_ready) decode_word(data_word);
      if (cfg_wr_en) sixteen_mode = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (event_results.size() == 0) begin
          $error("unexpected result transaction, channel %0d", channel);
          fail_count++;
        end else begin
          want = event_results.pop_front();
          check_field("channel", want.channel, channel);
          check_field("adc_value", want.adc, adc_value);
          check_field("trigger_number", want.trig, trigger_number);
          check_field("trigger_valid", want.trig_ok, trigger_valid);
          check_field("data_error", want.err, data_error);
          check_field("last", want.last, last);
          checked_count++;
        end
      end
    end
    pending_count = event_results.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the event word deframer. A directed sequence hits wrong word
// types in every phase, fillers, a zero-count header, out-of-range channels
// and value extremes; then randomized events under both channel-index modes,
// with random input gaps and output stalls in all but the first segment.
// ----------------------------------------------------------------------------
module tb
  import qdc_ewd_pkg::*;
();

  localparam int NumCh       = NumChannelsDefault;
  localparam int DrainCycles = NumCh + 8;
  localparam int StallLimit  = 2000;
  localparam int SegmentLen  = 125;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic               cfg_wr_data = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [WordW-1:0]   data_word = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [ChanW-1:0]   channel;
  logic [AdcOutW-1:0] adc_value;
  logic [TrigW-1:0]   trigger_number;
  logic               trigger_valid;
  logic               data_error;
  logic               last;

  int   mismatches;
  int   outstanding;
  int   results_checked;
  int   words_sent = 0;
  int   stall_cycles = 0;
  logic quiet = 1'b0;
  logic mode_now = 1'b0;

  always #1 clk = ~clk;

  qdc_event_word_deframer #(.NUM_CHANNELS(NumCh)) uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_word      (data_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .channel        (channel),
    .adc_value      (adc_value),
    .trigger_number (trigger_number),
    .trigger_valid  (trigger_valid),
    .data_error     (data_error),
    .last           (last)
  );

  qdc_ewd_checker #(.NUM_CHANNELS(NumCh)) u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .data_word       (data_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .channel         (channel),
    .adc_value       (adc_value),
    .trigger_number  (trigger_number),
    .trigger_valid   (trigger_valid),
    .data_error      (data_error),
    .last            (last),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  always @(posedge clk) out_ready <= quiet || ($urandom_range(0, 99) >= 8);

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("Timeout: no transaction for %0d cycles", StallLimit);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [WordW-1:0] make_word(input word_type_t wt);
    logic [WordW-1:0] w;
    w = $urandom;
    w[26:25] = wt;
    return w;
  endfunction

  function automatic logic [WordW-1:0] build_header(input logic [CountW-1:0] cnt);
    logic [WordW-1:0] w;
    w = make_word(WT_HEADER);
    w[13:8] = cnt;
    return w;
  endfunction

  function automatic logic [WordW-1:0] make_data(input logic [5:0] ch,
                                                 input logic [AdcW-1:0] adc);
    logic [WordW-1:0] w;
    w = make_word(WT_DATA);
    if (mode_now) w[22:17] = ch;
    else w[21:16] = ch;
    w[AdcW-1:0] = adc;
    return w;
  endfunction

  function automatic logic [WordW-1:0] make_eob(input logic [TrigW-1:0] trig);
    logic [WordW-1:0] w;
    w = make_word(WT_EOB);
    w[TrigW-1:0] = trig;
    return w;
  endfunction

  task automatic send_word(input logic [WordW-1:0] w);
    if (!quiet) begin
      while ($urandom_range(0, 99) < 8) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid  <= 1'b1;
    data_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (w[26:25] != WT_FILLER) words_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    mode_now = m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_event();
    int unsigned      pick;
    int unsigned      cnt;
    int unsigned      ch;
    logic [TrigW-1:0] trig;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      send_word($urandom);
    end else begin
      cnt = ($urandom_range(0, 15) == 0) ? $urandom_range(11, 63) : $urandom_range(0, 10);
      send_word(build_header(cnt[CountW-1:0]));
      for (int k = 0; k < cnt; k++) begin
        if ($urandom_range(0, 99) < 5) send_word(make_word(WT_FILLER));
        if ($urandom_range(0, 99) < 3)
          send_word(make_word($urandom_range(0, 1) ? WT_HEADER : WT_EOB));
        ch = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 31) : $urandom_range(32, 63);
        send_word(make_data(ch[5:0], AdcW'($urandom)));
      end
      // broken close: a wrong word ends the event before the real trailer
      if ($urandom_range(0, 99) < 10) send_word(make_word(pick[0] ? WT_HEADER : WT_DATA));
      case ($urandom_range(0, 9))
        0:       trig = '0;
        1:       trig = '1;
        default: trig = TrigW'($urandom);
      endcase
      send_word(make_eob(trig));
    end
  endtask

  task automatic random_segment(input int n);
    int stop_at;
    stop_at = words_sent + n;
    while (words_sent < stop_at) random_event();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_word(make_word(WT_DATA));        // wrong type while waiting for a header
    send_word(make_word(WT_FILLER));
    send_word(build_header(6'd0));        // empty event, straight to trailer
    send_word(make_word(WT_FILLER));
    send_word(make_eob(24'hFFFFFF));
    send_word(build_header(6'd3));
    send_word(make_data(6'd0, 12'hFFF));
    send_word(make_word(WT_FILLER));
    send_word(make_eob(24'h000001));      // trailer during channel data
    send_word(make_data(6'd31, 12'h000));
    send_word(make_data(6'd40, 12'hABC)); // index beyond the store
    send_word(build_header(6'd5));        // wrong closing word
    send_word(make_eob(24'h000000));
    send_word(build_header(6'd2));
    send_word(make_data(6'd63, 12'h5A5));
    send_word(make_data(6'd32, 12'hA5A));
    send_word(make_eob(TrigW'($urandom)));

    wait_idle();
    set_mode(1'b1);
    quiet = 1'b1;
    random_segment(SegmentLen);
    quiet = 1'b0;

    wait_idle();
    set_mode(1'b0);
    random_segment(SegmentLen);

    wait_idle();
    set_mode(1'b1);
    random_segment(SegmentLen);

    wait_idle();
    @(negedge clk);
    $display("Covered %0d readout words across both channel-index modes", words_sent);
    $display("Checked %0d channel results, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/qdc_ewd_pkg.sv
hw/rtl/qdc_ewd_ctrl.sv
hw/rtl/qdc_ewd_datapath.sv
hw/rtl/qdc_event_word_deframer.sv
tb/qdc_ewd_checker.sv
tb/tb.sv
